@@ rtl/core/grc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, widths and codes of the grid ray caster.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int DEF_GRID_COLS = 32;
  localparam int DEF_GRID_ROWS = 32;
  localparam int DEF_CELL_SIZE = 64;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_X    = 2'd0;
  localparam logic [1:0] REG_START_Y    = 2'd1;
  localparam logic [1:0] REG_ALONG_EPS  = 2'd2;
  localparam logic [1:0] REG_ACROSS_EPS = 2'd3;

  localparam int CFG_W = 27;
  localparam logic [15:0] EPS_RESET = 16'd64;

  // Opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Cell index units: position below 2^34, cell size in Q16.16 below 2^27,
  // quotient below 2^11.
  localparam int IDX_NW = 34;
  localparam int IDX_DW = 27;
  localparam int IDX_QW = 11;

  // Step setup divider: |offset * component| below 2^42 over a 16-bit magnitude.
  localparam int SDIV_NW = 42;
  localparam int SDIV_DW = 16;
  localparam int SDIV_QW = 42;

  localparam int P_W   = 34;
  localparam int S_W   = 44;
  localparam int STS_W = 43;
  localparam int POS_W = 36;

  // Multiplier operand selection.
  localparam logic [2:0] MUL_PS = 3'd0;
  localparam logic [2:0] MUL_CS = 3'd1;
  localparam logic [2:0] MUL_VX = 3'd2;
  localparam logic [2:0] MUL_VY = 3'd3;
  localparam logic [2:0] MUL_HX = 3'd4;
  localparam logic [2:0] MUL_HY = 3'd5;

  // Squared length accumulator operations.
  localparam logic [2:0] ACC_NONE  = 3'd0;
  localparam logic [2:0] ACC_V_SET = 3'd1;
  localparam logic [2:0] ACC_V_ADD = 3'd2;
  localparam logic [2:0] ACC_H_SET = 3'd3;
  localparam logic [2:0] ACC_H_ADD = 3'd4;

  typedef struct packed {
    logic              opcode;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [4:0]        cell_row;
    logic [4:0]        cell_col;
    logic              cell_wall;
  } grc_in_t;

  typedef struct packed {
    logic signed [31:0] hit_vec_x;
    logic signed [31:0] hit_vec_y;
    logic               hit_side;
  } grc_out_t;

  typedef struct packed {
    logic       load;
    logic       clr_wr;
    logic       cell_wr;
    logic       horiz;
    logic       base_go;
    logic       set_p;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       sdiv_go;
    logic       set_s;
    logic       set_sts;
    logic       probe_go;
    logic       step;
    logic       save_sat;
    logic       save_vec;
    logic [2:0] acc_op;
    logic       out_load;
  } grc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic opcode;
    logic dp_zero;
    logic idx_busy;
    logic sdiv_busy;
    logic ovf;
    logic steps_done;
    logic outside;
    logic wall;
    logic out_free;
  } grc_stat_t;

endpackage

@@ rtl/core/grc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/grc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div #(
  parameter int NW = 42,
  parameter int DW = 16,
  parameter int QW = 42
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quot
);

  // The caller guarantees that the quotient fits in QW bits.
  localparam int DSW  = DW + QW - 1;
  localparam int CMPW = (NW > DSW) ? NW : DSW;
  localparam int CW   = $clog2(QW + 1);

  logic [NW-1:0]  rem;
  logic [DSW-1:0] dsh;
  logic [CW-1:0]  cnt;
  logic           ge;

  assign busy = (cnt != '0);
  assign ge   = (CMPW'(rem) >= CMPW'(dsh));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsh  <= {divisor, {(QW-1){1'b0}}};
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - NW'(dsh);
      end
      quot <= {quot[QW-2:0], ge};
      dsh  <= dsh >> 1;
    end
  end

endmodule

@@ rtl/core/grc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_ctrl
// Sequencer of the ray caster: map clearing, cell writes and the two marches.
// ----------------------------------------------------------------------------
module grc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  grc_pkg::grc_stat_t stat,
  output grc_pkg::grc_cmd_t  cmd
);
  import grc_pkg::*;

  localparam logic [4:0] ST_CLEAR    = 5'd0;
  localparam logic [4:0] ST_IDLE     = 5'd1;
  localparam logic [4:0] ST_DISPATCH = 5'd2;
  localparam logic [4:0] ST_START    = 5'd3;
  localparam logic [4:0] ST_BASE     = 5'd4;
  localparam logic [4:0] ST_MUL1     = 5'd5;
  localparam logic [4:0] ST_DIV1     = 5'd6;
  localparam logic [4:0] ST_WAIT1    = 5'd7;
  localparam logic [4:0] ST_MUL2     = 5'd8;
  localparam logic [4:0] ST_DIV2     = 5'd9;
  localparam logic [4:0] ST_WAIT2    = 5'd10;
  localparam logic [4:0] ST_CHECK    = 5'd11;
  localparam logic [4:0] ST_PROBE    = 5'd12;
  localparam logic [4:0] ST_READ     = 5'd13;
  localparam logic [4:0] ST_SQ0      = 5'd14;
  localparam logic [4:0] ST_SQ1      = 5'd15;
  localparam logic [4:0] ST_SQ2      = 5'd16;
  localparam logic [4:0] ST_SQ3      = 5'd17;
  localparam logic [4:0] ST_SQ4      = 5'd18;
  localparam logic [4:0] ST_OUT      = 5'd19;

  logic [4:0] state, state_next;
  logic       horiz, horiz_next;
  logic       march_end;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      horiz <= 1'b0;
    end else begin
      state <= state_next;
      horiz <= horiz_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.horiz   = horiz;
    cmd.acc_op  = ACC_NONE;
    cmd.mul_sel = MUL_PS;
    state_next  = state;
    horiz_next  = horiz;
    march_end   = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.opcode == OP_CAST) begin
          horiz_next = 1'b0;
          state_next = ST_START;
        end else begin
          cmd.cell_wr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_START: begin
        if (stat.dp_zero) begin
          cmd.save_sat = 1'b1;
          march_end    = 1'b1;
        end else begin
          cmd.base_go = 1'b1;
          state_next  = ST_BASE;
        end
      end
      ST_BASE: begin
        if (!stat.idx_busy) begin
          cmd.set_p  = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PS;
        state_next  = ST_DIV1;
      end
      ST_DIV1: begin
        cmd.sdiv_go = 1'b1;
        state_next  = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (!stat.sdiv_busy) begin
          cmd.set_s  = 1'b1;
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CS;
        state_next  = ST_DIV2;
      end
      ST_DIV2: begin
        cmd.sdiv_go = 1'b1;
        state_next  = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (!stat.sdiv_busy) begin
          cmd.set_sts = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.steps_done) begin
          cmd.save_vec = 1'b1;
          march_end    = 1'b1;
        end else if (stat.ovf) begin
          cmd.save_sat = 1'b1;
          march_end    = 1'b1;
        end else begin
          cmd.probe_go = 1'b1;
          state_next   = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!stat.idx_busy) begin
          if (stat.outside) begin
            cmd.save_vec = 1'b1;
            march_end    = 1'b1;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (stat.wall) begin
          cmd.save_vec = 1'b1;
          march_end    = 1'b1;
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_SQ0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VX;
        state_next  = ST_SQ1;
      end
      ST_SQ1: begin
        cmd.acc_op  = ACC_V_SET;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VY;
        state_next  = ST_SQ2;
      end
      ST_SQ2: begin
        cmd.acc_op  = ACC_V_ADD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HX;
        state_next  = ST_SQ3;
      end
      ST_SQ3: begin
        cmd.acc_op  = ACC_H_SET;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HY;
        state_next  = ST_SQ4;
      end
      ST_SQ4: begin
        cmd.acc_op = ACC_H_ADD;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // The vertical march is followed by the horizontal one, then the compare.
    if (march_end) begin
      if (!horiz) begin
        horiz_next = 1'b1;
        state_next = ST_START;
      end else begin
        state_next = ST_SQ0;
      end
    end
  end

endmodule

@@ rtl/core/grc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_dp
// Datapath of the ray caster: registers, divider, multiplier and wall map.
// ----------------------------------------------------------------------------
module grc_dp #(
  parameter int GRID_COLS = 32,
  parameter int GRID_ROWS = 32,
  parameter int CELL_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [26:0]         cfg_data,
  input  grc_pkg::grc_in_t    in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output grc_pkg::grc_out_t   out_data,
  input  grc_pkg::grc_cmd_t   cmd,
  output grc_pkg::grc_stat_t  stat
);
  import grc_pkg::*;

  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int AW        = $clog2(CELLS);
  localparam int MAX_STEPS = GRID_COLS + GRID_ROWS + 2;
  localparam int NCW       = $clog2(MAX_STEPS + 1);

  localparam logic [IDX_DW-1:0] CELL_Q = IDX_DW'(CELL_SIZE * 65536);
  localparam logic signed [POS_W-1:0] COL_LIM =
    POS_W'(longint'(GRID_COLS) * longint'(CELL_SIZE) * 64'sd65536);
  localparam logic signed [POS_W-1:0] ROW_LIM =
    POS_W'(longint'(GRID_ROWS) * longint'(CELL_SIZE) * 64'sd65536);

  // Cell index: the integer part of a position over CELL_SIZE, found by a
  // reciprocal multiplication that is exact for every 18-bit input.
  localparam int IDX_XW = IDX_NW - 16;
  localparam int RCP_SH = IDX_XW + $clog2(CELL_SIZE);
  localparam int RCP_W  = RCP_SH + 1;
  localparam int RCP_PW = IDX_XW + RCP_W;
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_SH) + 64'(CELL_SIZE) - 64'd1) / 64'(CELL_SIZE));

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [31:0] sat_comp(input logic signed [15:0] d);
    if (d == 16'sd0) begin
      sat_comp = 32'h0000_0000;
    end else if (d[15]) begin
      sat_comp = 32'h8000_0000;
    end else begin
      sat_comp = 32'h7fff_ffff;
    end
  endfunction

  // Configuration registers.
  logic [26:0] start_x, start_y;
  logic [15:0] along_eps, across_eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= '0;
      start_y    <= '0;
      along_eps  <= EPS_RESET;
      across_eps <= EPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_X:    start_x    <= cfg_data;
        REG_START_Y:    start_y    <= cfg_data;
        REG_ALONG_EPS:  along_eps  <= cfg_data[15:0];
        REG_ACROSS_EPS: across_eps <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  grc_in_t item;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  // March axis selection: p is the stepped axis, s the other.
  logic signed [15:0] dp, ds;
  logic [26:0]        sp, ss;
  logic               dp_neg, ds_neg;
  logic [15:0]        dp_mag, ds_mag;

  assign dp     = cmd.horiz ? item.dir_y : item.dir_x;
  assign ds     = cmd.horiz ? item.dir_x : item.dir_y;
  assign sp     = cmd.horiz ? start_y : start_x;
  assign ss     = cmd.horiz ? start_x : start_y;
  assign dp_neg = dp[15];
  assign ds_neg = ds[15];
  assign dp_mag = dp_neg ? 16'(-dp) : 16'(dp);
  assign ds_mag = ds_neg ? 16'(-ds) : 16'(ds);

  logic signed [P_W-1:0]   p;
  logic signed [S_W-1:0]   s;
  logic signed [STS_W-1:0] sts;
  logic [NCW-1:0]          n;
  logic [P_W-1:0]          p_abs;

  assign p_abs = p[P_W-1] ? P_W'(-p) : P_W'(p);

  // Results of the two marches.
  logic signed [31:0] vx, vy, hx, hy;
  logic               vsat, hsat;

  // Shared multiplier with registered product.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] acc_v, acc_h;

  always_comb begin
    case (cmd.mul_sel)
      MUL_PS: begin
        mul_a = p_abs[31:0];
        mul_b = 32'(ds_mag);
      end
      MUL_CS: begin
        mul_a = 32'(CELL_Q);
        mul_b = 32'(ds_mag);
      end
      MUL_VX: begin
        mul_a = abs32(vx);
        mul_b = abs32(vx);
      end
      MUL_VY: begin
        mul_a = abs32(vy);
        mul_b = abs32(vy);
      end
      MUL_HX: begin
        mul_a = abs32(hx);
        mul_b = abs32(hx);
      end
      MUL_HY: begin
        mul_a = abs32(hy);
        mul_b = abs32(hy);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (cmd.acc_op)
      ACC_V_SET: acc_v <= prod;
      ACC_V_ADD: acc_v <= acc_v + prod;
      ACC_H_SET: acc_h <= prod;
      ACC_H_ADD: acc_h <= acc_h + prod;
      default: ;
    endcase
  end

  // Probe positions, nudged away from the crossed line.
  logic signed [POS_W-1:0] eps_p, eps_s, pos_p, pos_s;

  assign eps_p = p[P_W-1] ? -$signed({20'b0, along_eps}) : $signed({20'b0, along_eps});
  assign eps_s = s[S_W-1] ? -$signed({20'b0, across_eps}) : $signed({20'b0, across_eps});
  assign pos_p = $signed({9'b0, sp}) + {{(POS_W-P_W){p[P_W-1]}}, p} + eps_p;
  assign pos_s = $signed({9'b0, ss}) + $signed(s[POS_W-1:0]) + eps_s;

  // Cell index units; unit a also splits the start coordinate. The operand
  // is captured first and the quotient is registered in the next cycle. Positions
  // at or beyond the grid limit are judged outside without the quotient.
  logic              idx_busy;
  logic [IDX_XW-1:0] x_a, x_b;
  logic [RCP_PW-1:0] rcp_a, rcp_b;
  logic [IDX_QW-1:0] q_a, q_b;
  logic [IDX_NW-1:0] dvd_a;

  assign dvd_a = cmd.base_go ? IDX_NW'(sp) : pos_p[IDX_NW-1:0];
  assign rcp_a = RCP_PW'(x_a) * RCP_PW'(RCP_M);
  assign rcp_b = RCP_PW'(x_b) * RCP_PW'(RCP_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_busy <= 1'b0;
    end else begin
      idx_busy <= cmd.base_go | cmd.probe_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.base_go | cmd.probe_go) begin
      x_a <= dvd_a[IDX_NW-1:16];
      x_b <= pos_s[IDX_NW-1:16];
    end
    if (idx_busy) begin
      q_a <= IDX_QW'(rcp_a >> RCP_SH);
      q_b <= IDX_QW'(rcp_b >> RCP_SH);
    end
  end

  // Offset of the start coordinate inside its cell.
  logic [IDX_XW-1:0] base_rem_hi;
  logic [P_W-1:0]    rem_a;

  assign base_rem_hi = IDX_XW'(32'(sp[26:16]) - 32'(q_a) * CELL_SIZE);
  assign rem_a       = P_W'({base_rem_hi, sp[15:0]});

  // Step setup divider.
  logic               sdiv_busy;
  logic [SDIV_QW-1:0] sq;

  grc_div #(.NW(SDIV_NW), .DW(SDIV_DW), .QW(SDIV_QW)) u_sdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sdiv_go),
    .dividend (prod[SDIV_NW-1:0]),
    .divisor  (dp_mag),
    .busy     (sdiv_busy),
    .quot     (sq)
  );

  logic signed [S_W-1:0]   sq_s;
  logic signed [STS_W-1:0] sq_sts;

  assign sq_s   = $signed(S_W'(sq));
  assign sq_sts = $signed(STS_W'(sq));

  always_ff @(posedge clk) begin
    if (cmd.set_p) begin
      p <= dp_neg ? -$signed(rem_a) : $signed(P_W'(CELL_Q)) - $signed(rem_a);
    end else if (cmd.step) begin
      p <= dp_neg ? p - $signed(P_W'(CELL_Q)) : p + $signed(P_W'(CELL_Q));
    end
    if (cmd.set_s) begin
      s <= (p[P_W-1] ^ ds_neg ^ dp_neg) ? -sq_s : sq_s;
    end else if (cmd.step) begin
      s <= s + {{(S_W-STS_W){sts[STS_W-1]}}, sts};
    end
    if (cmd.set_sts) begin
      sts <= ds_neg ? -sq_sts : sq_sts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cmd.set_sts) begin
      n <= '0;
    end else if (cmd.step) begin
      n <= n + 1'b1;
    end
  end

  // Probe judgment and wall map address.
  logic signed [POS_W-1:0] lim_p, lim_s;
  logic                    out_p, out_s;
  logic [IDX_QW-1:0]       row_q, col_q;
  logic [AW-1:0]           rd_addr;

  assign lim_p   = cmd.horiz ? ROW_LIM : COL_LIM;
  assign lim_s   = cmd.horiz ? COL_LIM : ROW_LIM;
  assign out_p   = pos_p[POS_W-1] || (pos_p >= lim_p) || (q_a == '0);
  assign out_s   = pos_s[POS_W-1] || (pos_s >= lim_s) || (q_b == '0);
  assign col_q   = cmd.horiz ? q_b : q_a;
  assign row_q   = cmd.horiz ? q_a : q_b;
  assign rd_addr = AW'(32'(row_q) * GRID_COLS + 32'(col_q));

  logic [AW-1:0] clr_addr, cell_addr, wr_addr;
  logic          cell_in_grid, ram_we, ram_wdata, wall;

  assign cell_addr    = AW'(32'(item.cell_row) * GRID_COLS + 32'(item.cell_col));
  assign cell_in_grid = (32'(item.cell_row) < GRID_ROWS) && (32'(item.cell_col) < GRID_COLS);
  assign wr_addr      = cmd.clr_wr ? clr_addr : cell_addr;
  assign ram_wdata    = cmd.clr_wr ? 1'b0 : item.cell_wall;
  assign ram_we       = cmd.clr_wr | (cmd.cell_wr & cell_in_grid);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  grc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (wall)
  );

  always_ff @(posedge clk) begin
    if (cmd.save_sat) begin
      if (cmd.horiz) begin
        hsat <= 1'b1;
      end else begin
        vsat <= 1'b1;
      end
    end else if (cmd.save_vec) begin
      if (cmd.horiz) begin
        hsat <= 1'b0;
        hy   <= p[31:0];
        hx   <= s[31:0];
      end else begin
        vsat <= 1'b0;
        vx   <= p[31:0];
        vy   <= s[31:0];
      end
    end
  end

  // Output register; a tie goes to the horizontal march.
  logic pick_v;

  assign pick_v = !vsat && (hsat || (acc_v < acc_h));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.hit_side <= !pick_v;
      if (pick_v) begin
        out_data.hit_vec_x <= vx;
        out_data.hit_vec_y <= vy;
      end else if (hsat) begin
        out_data.hit_vec_x <= sat_comp(item.dir_x);
        out_data.hit_vec_y <= sat_comp(item.dir_y);
      end else begin
        out_data.hit_vec_x <= hx;
        out_data.hit_vec_y <= hy;
      end
    end
  end

  always_comb begin
    stat.clr_done   = (clr_addr == AW'(CELLS - 1));
    stat.opcode     = item.opcode;
    stat.dp_zero    = (dp == 16'sd0);
    stat.idx_busy   = idx_busy;
    stat.sdiv_busy  = sdiv_busy;
    stat.ovf        = (p[P_W-1:31] != '0 && p[P_W-1:31] != '1) ||
                      (s[S_W-1:31] != '0 && s[S_W-1:31] != '1);
    stat.steps_done = (n == NCW'(MAX_STEPS));
    stat.outside    = out_p | out_s;
    stat.wall       = wall;
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

@@ rtl/core/grid_ray_caster.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_caster
// Casts a ray through a wall grid with two line marches; returns the nearer hit.
// ----------------------------------------------------------------------------
// Channel   Signals                         Transaction
// in        in_valid, in_stall, in_data     valid high and stall low
// out       out_valid, out_stall, out_data  valid high and stall low
// cfg       cfg_we, cfg_index, cfg_data     cfg_we high
//
// A cell write is loaded and then written in the dispatch state. A ray runs two
// marches and then compares their squared lengths: each probe of a cell runs the
// cell index units, and step setup runs the 42-step divider twice per march.
// After reset the wall map is cleared cell by cell with in_stall high. A finished
// result waits in the output register while the next transaction is taken; a ray
// only completes once that register is free.
// ----------------------------------------------------------------------------
module grid_ray_caster #(
  parameter int GRID_COLS = grc_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = grc_pkg::DEF_GRID_ROWS,
  parameter int CELL_SIZE = grc_pkg::DEF_CELL_SIZE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  grc_pkg::grc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output grc_pkg::grc_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [26:0]       cfg_data
);
  import grc_pkg::*;

  grc_cmd_t  cmd;
  grc_stat_t stat;

  grc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  grc_dp #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .CELL_SIZE (CELL_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
